>>> hdl/bevev_pkg.sv
// types and constants shared by the boundary edge value evaluator
package bevev_pkg;

	// boundary condition types
	typedef enum logic [2:0] {
		MODE_REFLECT     = 3'd0,
		MODE_DIRICHLET   = 3'd1,
		MODE_TRANSMIT    = 3'd2,
		MODE_TIME        = 3'd3,
		MODE_DISCHARGE   = 3'd4,
		MODE_TRANS_STAGE = 3'd5,
		MODE_SERIES      = 3'd6,
		MODE_REFLECT_ALT = 3'd7
	} mode_t;

	// field widths: values are Q16.16, normals Q2.14
	localparam int VAL_W   = 32;
	localparam int NRM_W   = 16;
	localparam int FRAC_SH = 14;

	// one boundary edge
	typedef struct packed {
		mode_t                     mode;
		logic signed [VAL_W-1:0]   outer_stage;
		logic signed [VAL_W-1:0]   discharge;
		logic signed [VAL_W-1:0]   interior_stage;
		logic signed [VAL_W-1:0]   interior_bed;
		logic signed [VAL_W-1:0]   interior_height;
		logic signed [VAL_W-1:0]   interior_xmom;
		logic signed [VAL_W-1:0]   interior_ymom;
		logic signed [NRM_W-1:0]   normal_x;
		logic signed [NRM_W-1:0]   normal_y;
	} edge_item_t;

	// boundary values for one edge
	typedef struct packed {
		logic signed [VAL_W-1:0] edge_stage;
		logic signed [VAL_W-1:0] edge_bed;
		logic signed [VAL_W-1:0] edge_height;
		logic signed [VAL_W-1:0] edge_xmom;
		logic signed [VAL_W-1:0] edge_ymom;
	} result_t;

endpackage

>>> hdl/bevev_if.sv
// valid/ready channels for edge items and result items

interface bevev_edge_if import bevev_pkg::*; ();
	logic       valid;
	logic       ready;
	edge_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bevev_res_if import bevev_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/bevev_core.sv
// four-stage arithmetic datapath of the boundary edge value evaluator
module bevev_core import bevev_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       adv,
	input  edge_item_t item,
	output result_t    res
);

	localparam logic signed [63:0] SAT_HI   = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO   = ~SAT_HI;
	localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_SH - 1);

	// product and rounding widths
	localparam int PRD_W = VAL_W + NRM_W;         // q * n
	localparam int SUM_W = PRD_W + 2;             // q.n plus rounding
	localparam int DOT_W = SUM_W - FRAC_SH;       // rounded q.n
	localparam int PDN_W = DOT_W + NRM_W;         // d * n
	localparam int MOM_W = PDN_W - FRAC_SH + 4;   // momentum before saturation
	localparam int HGT_W = VAL_W + 1;

	// saturate to VALUE_WIDTH signed bits, keep the low field bits
	function automatic logic [VAL_W-1:0] sat_val(input logic signed [63:0] v);
		logic signed [63:0] c;
		c = v;
		if (c > SAT_HI) c = SAT_HI;
		if (c < SAT_LO) c = SAT_LO;
		return c[VAL_W-1:0];
	endfunction

	// stage 1: depth, stage selection, first products
	logic signed [HGT_W-1:0] diff;
	logic                    copy_int;

	mode_t                   mode_s1;
	logic signed [VAL_W-1:0] stage_s1, bed_s1, qx_s1, qy_s1;
	logic signed [HGT_W-1:0] height_s1;
	logic signed [NRM_W-1:0] nx_s1, ny_s1;
	logic signed [PRD_W-1:0] pxx_s1, pyy_s1, pdx_s1, pdy_s1;

	assign diff = HGT_W'(item.outer_stage) - HGT_W'(item.interior_bed);
	assign copy_int = (item.mode == MODE_REFLECT) || (item.mode == MODE_REFLECT_ALT)
		|| (item.mode == MODE_TRANS_STAGE);

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1  <= item.mode;
			stage_s1 <= copy_int ? item.interior_stage : item.outer_stage;
			bed_s1   <= item.interior_bed;
			if (copy_int) begin
				height_s1 <= HGT_W'(item.interior_height);
			end else if (diff < 0) begin
				height_s1 <= '0;
			end else begin
				height_s1 <= diff;
			end
			qx_s1  <= item.interior_xmom;
			qy_s1  <= item.interior_ymom;
			nx_s1  <= item.normal_x;
			ny_s1  <= item.normal_y;
			pxx_s1 <= PRD_W'(item.interior_xmom) * PRD_W'(item.normal_x);
			pyy_s1 <= PRD_W'(item.interior_ymom) * PRD_W'(item.normal_y);
			pdx_s1 <= PRD_W'(item.discharge) * PRD_W'(item.normal_x);
			pdy_s1 <= PRD_W'(item.discharge) * PRD_W'(item.normal_y);
		end
	end

	// stage 2: round the dot product and the inward discharge momentum
	logic signed [SUM_W-1:0] dot_sum, ndx_sum, ndy_sum;

	mode_t                   mode_s2;
	logic signed [VAL_W-1:0] stage_s2, bed_s2, qx_s2, qy_s2;
	logic signed [HGT_W-1:0] height_s2;
	logic signed [NRM_W-1:0] nx_s2, ny_s2;
	logic signed [DOT_W-1:0] d_s2, dmx_s2, dmy_s2;

	assign dot_sum = SUM_W'(pxx_s1) + SUM_W'(pyy_s1) + SUM_W'(RND_HALF);
	assign ndx_sum = SUM_W'(RND_HALF) - SUM_W'(pdx_s1);
	assign ndy_sum = SUM_W'(RND_HALF) - SUM_W'(pdy_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2   <= mode_s1;
			stage_s2  <= stage_s1;
			bed_s2    <= bed_s1;
			height_s2 <= height_s1;
			qx_s2     <= qx_s1;
			qy_s2     <= qy_s1;
			nx_s2     <= nx_s1;
			ny_s2     <= ny_s1;
			d_s2      <= DOT_W'(dot_sum >>> FRAC_SH);
			dmx_s2    <= DOT_W'(ndx_sum >>> FRAC_SH);
			dmy_s2    <= DOT_W'(ndy_sum >>> FRAC_SH);
		end
	end

	// stage 3: project the dot product back onto the normal
	mode_t                   mode_s3;
	logic signed [VAL_W-1:0] stage_s3, bed_s3, qx_s3, qy_s3;
	logic signed [HGT_W-1:0] height_s3;
	logic signed [DOT_W-1:0] dmx_s3, dmy_s3;
	logic signed [PDN_W-1:0] ex_s3, ey_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3   <= mode_s2;
			stage_s3  <= stage_s2;
			bed_s3    <= bed_s2;
			height_s3 <= height_s2;
			qx_s3     <= qx_s2;
			qy_s3     <= qy_s2;
			dmx_s3    <= dmx_s2;
			dmy_s3    <= dmy_s2;
			ex_s3     <= PDN_W'(d_s2) * PDN_W'(nx_s2);
			ey_s3     <= PDN_W'(d_s2) * PDN_W'(ny_s2);
		end
	end

	// stage 4: momentum by mode, saturation, output register
	logic signed [PDN_W+1:0] rfx, rfy, trx, try_v;
	logic signed [MOM_W-1:0] mx, my;

	assign rfx   = ((PDN_W+2)'(ex_s3) <<< 1) + (PDN_W+2)'(RND_HALF);
	assign rfy   = ((PDN_W+2)'(ey_s3) <<< 1) + (PDN_W+2)'(RND_HALF);
	assign trx   = (PDN_W+2)'(ex_s3) + (PDN_W+2)'(RND_HALF);
	assign try_v = (PDN_W+2)'(ey_s3) + (PDN_W+2)'(RND_HALF);

	always_comb begin
		case (mode_s3)
			MODE_TRANSMIT: begin
				mx = MOM_W'(trx >>> FRAC_SH);
				my = MOM_W'(try_v >>> FRAC_SH);
			end
			MODE_DISCHARGE: begin
				mx = MOM_W'(dmx_s3);
				my = MOM_W'(dmy_s3);
			end
			MODE_DIRICHLET, MODE_TIME, MODE_TRANS_STAGE, MODE_SERIES: begin
				mx = '0;
				my = '0;
			end
			default: begin
				mx = MOM_W'(qx_s3) - MOM_W'(rfx >>> FRAC_SH);
				my = MOM_W'(qy_s3) - MOM_W'(rfy >>> FRAC_SH);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.edge_stage  <= sat_val(64'(stage_s3));
			res.edge_bed    <= sat_val(64'(bed_s3));
			res.edge_height <= sat_val(64'(height_s3));
			res.edge_xmom   <= sat_val(64'(mx));
			res.edge_ymom   <= sat_val(64'(my));
		end
	end

endmodule

>>> hdl/boundary_edge_value_evaluator.sv
// Boundary edge value evaluator: boundary stage, bed, depth and momentum per edge.
//
// Channels: boundary (sink) takes one edge item: condition type, the tag's
// external stage and discharge, the interior stage, bed, depth and momentum,
// and the outward unit normal (Q16.16 values, Q2.14 normals). result
// (source) gives one item per edge: stage, bed, depth, x and y momentum,
// each saturated to VALUE_WIDTH signed bits and carried in a 32-bit field.
// Pipeline: acceptance to result valid passes three arithmetic register
// stages and the output register. Throughput: one edge per cycle unless
// stalled; the pipeline has no loop, so every stage takes a new item each
// cycle while it advances. Results leave in the order edges arrive.
// Stall: while a result waits and result.ready is low the whole pipeline
// holds, boundary.ready drops and no item is lost or repeated; empty stages
// ahead of the output do not collapse.
// Reset: arst_n clears the valid bits at once; the data registers are not
// reset, and boundary.ready is high as soon as reset is released.
module boundary_edge_value_evaluator import bevev_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	bevev_edge_if.sink  boundary,
	bevev_res_if.source result
);

	logic    adv;
	logic    vld_s1, vld_s2, vld_s3, vld_s4;
	result_t res;

	// the pipeline moves whenever the output register is free or being taken
	assign adv            = !vld_s4 || result.ready;
	assign boundary.ready = adv;
	assign result.valid   = vld_s4;
	assign result.data    = res;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= boundary.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// arithmetic datapath
	bevev_core #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_core (
		.clk  (clk),
		.adv  (adv),
		.item (boundary.data),
		.res  (res)
	);

	// an accepted item enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		boundary.valid && boundary.ready |=> vld_s1)
		else $error("accepted item missing from first stage");

	// a waiting result blocks new items
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !result.ready |-> !boundary.ready)
		else $error("item accepted while the pipeline is stalled");

	// items inside the pipeline survive a stall
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && vld_s4 && !result.ready |=> vld_s3 && vld_s4)
		else $error("item dropped during a stall");

	// a result is delivered only after an item passed through
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s4) |-> $past(vld_s3))
		else $error("result appeared without an item");

endmodule

>>> sim/bevev_checker.sv
// checker for the boundary edge value evaluator: predicts each edge's boundary values and compares
module bevev_checker import bevev_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	bevev_edge_if boundary,
	bevev_res_if  result,
	output int    mismatches,
	output int    outstanding
);

	// boundary values predicted for accepted edges, oldest first
	result_t pending_values[$];
	result_t observed;
	result_t predicted;
	int      results_seen;

	initial begin
		mismatches   = 0;
		outstanding  = 0;
		results_seen = 0;
	end

	// Q16.16 times Q2.14 back to Q16.16: add half an lsb, then floor
	function automatic longint round_q14(longint product);
		return (product + 64'sd8192) >>> FRAC_SH;
	endfunction

	// saturate to the signed value width, carried in a 32-bit field
	function automatic logic [VAL_W-1:0] clamp_value(longint v);
		longint top_value;
		longint bottom_value;
		top_value    = longint'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
		bottom_value = -top_value - 1;
		if (v > top_value)
			v = top_value;
		if (v < bottom_value)
			v = bottom_value;
		return v[VAL_W-1:0];
	endfunction

	// boundary stage, bed, depth and momentum for one edge
	function automatic result_t boundary_values(edge_item_t e);
		longint ext, dis, ist, bed, ih, qx, qy, nx, ny;
		longint dot, stage, height, xmom, ymom;
		result_t r;
		ext = $signed(e.outer_stage);
		dis = $signed(e.discharge);
		ist = $signed(e.interior_stage);
		bed = $signed(e.interior_bed);
		ih  = $signed(e.interior_height);
		qx  = $signed(e.interior_xmom);
		qy  = $signed(e.interior_ymom);
		nx  = $signed(e.normal_x);
		ny  = $signed(e.normal_y);

		// stage and depth: copied from the interior or derived from the external stage
		case (e.mode)
			MODE_REFLECT, MODE_REFLECT_ALT, MODE_TRANS_STAGE: begin
				stage  = ist;
				height = ih;
			end
			default: begin
				stage  = ext;
				height = ext - bed;
				if (height < 0)
					height = 0;
			end
		endcase

		// momentum by condition type; unknown types reflect
		case (e.mode)
			MODE_TRANSMIT: begin
				dot  = round_q14(qx * nx + qy * ny);
				xmom = round_q14(dot * nx);
				ymom = round_q14(dot * ny);
			end
			MODE_DISCHARGE: begin
				xmom = round_q14(-(dis * nx));
				ymom = round_q14(-(dis * ny));
			end
			MODE_DIRICHLET, MODE_TIME, MODE_TRANS_STAGE, MODE_SERIES: begin
				xmom = 0;
				ymom = 0;
			end
			default: begin
				dot  = round_q14(qx * nx + qy * ny);
				xmom = qx - round_q14(2 * dot * nx);
				ymom = qy - round_q14(2 * dot * ny);
			end
		endcase

		r.edge_stage  = clamp_value(stage);
		r.edge_bed    = clamp_value(bed);
		r.edge_height = clamp_value(height);
		r.edge_xmom   = clamp_value(xmom);
		r.edge_ymom   = clamp_value(ymom);
		return r;
	endfunction

	// one line per failure, always counted
	task automatic report(input string msg);
		$display("%0t result %0d: %s", $time, results_seen, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string what, input logic signed [VAL_W-1:0] got,
		input logic signed [VAL_W-1:0] want);
		if (got !== want)
			report($sformatf("%s got %0d expected %0d", what, got, want));
	endtask

	// record each accepted edge, check each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (boundary.valid && boundary.ready)
				pending_values.push_back(boundary_values(boundary.data));
			if (result.valid && result.ready) begin
				observed = result.data;
				if (pending_values.size() == 0) begin
					report("result item with no edge waiting");
				end else begin
					predicted = pending_values.pop_front();
					compare_field("edge_stage", observed.edge_stage, predicted.edge_stage);
					compare_field("edge_bed", observed.edge_bed, predicted.edge_bed);
					compare_field("edge_height", observed.edge_height, predicted.edge_height);
					compare_field("edge_xmom", observed.edge_xmom, predicted.edge_xmom);
					compare_field("edge_ymom", observed.edge_ymom, predicted.edge_ymom);
				end
				results_seen++;
			end
			outstanding <= pending_values.size();
		end
	end

endmodule

>>> sim/tb_top.sv
// testbench top for the boundary edge value evaluator: clock, reset, edge stimulus and verdict
module tb_top import bevev_pkg::*; ();

	localparam int VALUE_WIDTH  = 32;
	localparam int RANDOM_EDGES = 1850;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 80;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   edges_sent;
	int   cycle_count;

	edge_item_t directed_edges[$];

	bevev_edge_if boundary_ch();
	bevev_res_if  result_ch();

	boundary_edge_value_evaluator #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.boundary (boundary_ch),
		.result   (result_ch)
	);

	bevev_checker #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.boundary    (boundary_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// give up on a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("boundary_edge_value_evaluator regression: fail");
		$finish;
	end

	// result side: one long hold-off, a stretch of steady ready, random stalls elsewhere
	initial begin
		bit held;
		held = 1'b0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && edges_sent >= 300) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else if (edges_sent >= 900 && edges_sent < 1200) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= 33);
			end
		end
	end

	function automatic edge_item_t make_edge(input mode_t m,
		input logic signed [VAL_W-1:0] ext, input logic signed [VAL_W-1:0] dis,
		input logic signed [VAL_W-1:0] ist, input logic signed [VAL_W-1:0] bed,
		input logic signed [VAL_W-1:0] ih, input logic signed [VAL_W-1:0] qx,
		input logic signed [VAL_W-1:0] qy, input logic signed [NRM_W-1:0] nx,
		input logic signed [NRM_W-1:0] ny);
		edge_item_t e;
		e.mode            = m;
		e.outer_stage     = ext;
		e.discharge       = dis;
		e.interior_stage  = ist;
		e.interior_bed    = bed;
		e.interior_height = ih;
		e.interior_xmom   = qx;
		e.interior_ymom   = qy;
		e.normal_x        = nx;
		e.normal_y        = ny;
		return e;
	endfunction

	// mostly plausible water values, some full-range and a few at the extremes
	function automatic logic [VAL_W-1:0] random_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return 32'($urandom_range(2097152)) - 32'd1048576;
			4, 5, 6:    return $urandom;
			7:          return 32'h7fff_ffff;
			8:          return 32'h8000_0000;
			default:    return 32'($urandom_range(3)) - 32'd1;
		endcase
	endfunction

	// unit normals along the axes and diagonals, or anything within [-1, 1]
	function automatic logic [NRM_W-1:0] random_normal();
		case ($urandom_range(5))
			0:       return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
			1:       return 16'sd0;
			2:       return $urandom_range(1) ? 16'sd11585 : -16'sd11585;
			3, 4:    return 16'($urandom_range(32768)) - 16'd16384;
			default: return 16'($urandom_range(200)) - 16'd100;
		endcase
	endfunction

	function automatic edge_item_t random_edge();
		edge_item_t e;
		e.mode            = mode_t'($urandom_range(7));
		e.outer_stage     = random_value();
		e.discharge       = random_value();
		e.interior_stage  = random_value();
		e.interior_bed    = random_value();
		e.interior_height = random_value();
		e.interior_xmom   = random_value();
		e.interior_ymom   = random_value();
		e.normal_x        = random_normal();
		e.normal_y        = random_normal();
		// bed close to the external stage, so the depth clamp is hit from both sides
		if ($urandom_range(3) == 0)
			e.interior_bed = e.outer_stage + 32'($urandom_range(64)) - 32'd32;
		return e;
	endfunction

	// offer one edge, hold it until taken, then maybe leave a gap
	task automatic send_edge(input edge_item_t e);
		boundary_ch.data  <= e;
		boundary_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!boundary_ch.ready);
		edges_sent++;
		if (!(edges_sent >= 900 && edges_sent < 1200))
			while ($urandom_range(99) < 33) begin
				boundary_ch.valid <= 1'b0;
				@(posedge clk);
			end
	endtask

	// stop offering until every predicted result has come back
	task automatic wait_for_drain();
		boundary_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// stimulus and verdict
	initial begin
		edges_sent = 0;
		arst_n            <= 1'b0;
		boundary_ch.valid <= 1'b0;
		boundary_ch.data  <= '0;

		// typical cases of each condition type
		directed_edges.push_back(make_edge(MODE_REFLECT, 0, 0, 32'sh0002_8000, 32'sh0001_0000,
			32'sh0001_8000, 32'sh0000_c000, -32'sh0000_4000, 16'sd16384, 16'sd0));
		directed_edges.push_back(make_edge(MODE_REFLECT_ALT, 0, 0, 32'sh0003_0000,
			32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0002_0000, 16'sd11585,
			16'sd11585));
		directed_edges.push_back(make_edge(MODE_DIRICHLET, 32'sh0003_0000, 0, 0, 32'sh0001_0000,
			0, 32'sh0001_0000, 32'sh0001_0000, 16'sd16384, 16'sd0));
		// depth below zero is clamped, equal stage and bed gives zero
		directed_edges.push_back(make_edge(MODE_DIRICHLET, 32'sh0001_0000, 0, 0, 32'sh0003_0000,
			0, 0, 0, 16'sd0, 16'sd16384));
		directed_edges.push_back(make_edge(MODE_TIME, 32'sh0002_0000, 0, 0, 32'sh0002_0000,
			32'sh0005_0000, 32'sh0001_0000, -32'sh0001_0000, -16'sd16384, 16'sd0));
		// depth wider than the field saturates
		directed_edges.push_back(make_edge(MODE_SERIES, 32'sh7fff_ffff, 0, 0, 32'sh8000_0000,
			0, 0, 0, 16'sd0, -16'sd16384));
		directed_edges.push_back(make_edge(MODE_TRANSMIT, 32'sh0001_0000, 0, 0, 0, 0,
			32'sh0001_8000, -32'sh0002_0000, 16'sd0, -16'sd16384));
		directed_edges.push_back(make_edge(MODE_TRANSMIT, 0, 0, 0, 0, 0, 32'sh7fff_ffff,
			32'sh7fff_ffff, 16'sd16384, 16'sd16384));
		directed_edges.push_back(make_edge(MODE_DISCHARGE, 32'sh0001_0000, 32'sh0002_0000, 0, 0,
			0, 0, 0, 16'sd16384, 16'sd0));
		directed_edges.push_back(make_edge(MODE_DISCHARGE, 0, 32'sh8000_0000, 0, 0, 0, 0, 0,
			-16'sd16384, 16'sd16384));
		directed_edges.push_back(make_edge(MODE_TRANS_STAGE, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
			16'sd16384, 16'sd16384));
		// reflection overflowing both ways
		directed_edges.push_back(make_edge(MODE_REFLECT, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			-16'sd16384, -16'sd16384));
		directed_edges.push_back(make_edge(MODE_REFLECT, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			16'sd16384, 16'sd16384));
		// normals beyond unit length
		directed_edges.push_back(make_edge(MODE_REFLECT, 0, 0, 0, 0, 0, 32'sh0001_0000,
			-32'sh0003_0000, -16'sd32768, 16'sd32767));
		directed_edges.push_back(make_edge(MODE_TRANSMIT, 0, 0, 0, 0, 0, 32'sh7fff_ffff,
			32'sh8000_0000, 16'sd32767, -16'sd32768));
		directed_edges.push_back(make_edge(MODE_DISCHARGE, 0, 32'sh7fff_ffff, 0, 0, 0, 0, 0,
			-16'sd32768, 16'sd32767));
		// rounding: half an lsb goes up, just under goes down, negatives floor
		directed_edges.push_back(make_edge(MODE_TRANSMIT, 0, 0, 0, 0, 0, 32'sd1, 32'sd0,
			16'sd8192, 16'sd0));
		directed_edges.push_back(make_edge(MODE_TRANSMIT, 0, 0, 0, 0, 0, -32'sd1, 32'sd0,
			16'sd8192, 16'sd0));
		directed_edges.push_back(make_edge(MODE_REFLECT, 0, 0, 0, 0, 0, -32'sd3, 32'sd5,
			16'sd8193, -16'sd8191));
		directed_edges.push_back(make_edge(MODE_DISCHARGE, 0, -32'sd1, 0, 0, 0, 0, 0,
			16'sd8192, 16'sd8192));
		// non-unit normal inside range, all-zero edge, all-negative alternate reflective
		directed_edges.push_back(make_edge(MODE_REFLECT, 0, 0, 32'sh0001_0000, 0,
			32'sh0001_0000, 32'sh0000_8000, 32'sh0000_4000, 16'sd16384, 16'sd16384));
		directed_edges.push_back(make_edge(MODE_REFLECT, 0, 0, 0, 0, 0, 0, 0, 16'sd0, 16'sd0));
		directed_edges.push_back(make_edge(MODE_REFLECT_ALT, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
			-32'sd1, -32'sh0001_0000, -32'sh0002_0000, -16'sd11585, -16'sd11585));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_edges[i])
			send_edge(directed_edges[i]);

		for (int i = 0; i < RANDOM_EDGES; i++) begin
			if (i == 600)
				wait_for_drain();
			send_edge(random_edge());
		end

		wait_for_drain();
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("boundary_edge_value_evaluator regression: pass");
		else
			$display("boundary_edge_value_evaluator regression: fail");
		$finish;
	end

endmodule
